FILE: hw/rtl/tgarle_pkg.sv
// Shared types and constants of the run-length TGA pixel decoder.
package tgarle_pkg;

    // Configuration register indexes
    localparam logic CFG_IDX_W = 1'b1;
    localparam logic [0:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [0:0] REG_IMAGE_PIXELS    = 1'd1;

    // Packet header fields
    localparam logic [7:0] HDR_RUN_FLAG  = 8'h80;
    localparam logic [7:0] HDR_COUNT_MSK = 8'h7f;

    // Reset values of the configuration registers
    localparam logic [2:0]  BPP_RESET    = 3'd3;
    localparam logic [31:0] PIXELS_RESET = 32'd1;

    // Pixel width code: width in bytes minus one
    localparam logic [1:0] WCODE_RGB = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded pixel, before byte reordering
    typedef struct packed {
        logic [31:0] gather;
        logic [1:0]  wcode;
        logic [7:0]  count;
        logic        last;
    } pix_item_t;

endpackage

FILE: hw/rtl/tgarle_front.sv
// Front end: configuration registers, packet parsing, pixel gathering and run clipping.
module tgarle_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  byte_valid,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_image,
    output logic                  push,
    output tgarle_pkg::pix_item_t push_item
);
    import tgarle_pkg::*;

    logic [2:0]  bpp_reg;
    logic [31:0] img_pixels_reg;

    logic        expect_hdr_reg, expect_hdr_next;
    logic        is_run_reg, is_run_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        done_reg, done_next;

    // Effective state after an optional restart
    logic        e_expect, e_run, e_done;
    logic [7:0]  e_left;
    logic [1:0]  e_pos;
    logic [31:0] e_gather, e_rem;
    logic [2:0]  width;
    logic [31:0] gathered;
    logic [7:0]  count;
    logic [31:0] rem_after;
    logic        emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg        <= BPP_RESET;
            img_pixels_reg <= PIXELS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BYTES_PER_PIXEL: bpp_reg        <= cfg_wdata[2:0];
                REG_IMAGE_PIXELS:    img_pixels_reg <= cfg_wdata;
                default:             bpp_reg        <= bpp_reg;
            endcase
        end
    end

    always_comb begin
        if (bpp_reg == 3'd0) begin
            width = 3'd1;
        end else if (bpp_reg > 3'd4) begin
            width = 3'd4;
        end else begin
            width = bpp_reg;
        end
    end

    always_comb begin
        if (first_of_image) begin
            e_expect = 1'b1;
            e_run    = 1'b0;
            e_left   = 8'd0;
            e_pos    = 2'd0;
            e_gather = 32'd0;
            e_rem    = img_pixels_reg;
            e_done   = (img_pixels_reg == 32'd0);
        end else begin
            e_expect = expect_hdr_reg;
            e_run    = is_run_reg;
            e_left   = pkt_left_reg;
            e_pos    = byte_pos_reg;
            e_gather = gather_reg;
            e_rem    = remaining_reg;
            e_done   = done_reg;
        end

        expect_hdr_next = e_expect;
        is_run_next     = e_run;
        pkt_left_next   = e_left;
        byte_pos_next   = e_pos;
        gather_next     = e_gather;
        remaining_next  = e_rem;
        done_next       = e_done;
        emit            = 1'b0;

        gathered  = e_gather | ({24'd0, data_byte} << {e_pos, 3'b000});
        if (e_run) begin
            count = (e_rem < {24'd0, e_left}) ? e_rem[7:0] : e_left;
        end else begin
            count = 8'd1;
        end
        rem_after = e_rem - {24'd0, count};

        if (!e_done) begin
            if (e_expect) begin
                is_run_next     = (data_byte & HDR_RUN_FLAG) != 8'd0;
                pkt_left_next   = (data_byte & HDR_COUNT_MSK) + 8'd1;
                expect_hdr_next = 1'b0;
                byte_pos_next   = 2'd0;
                gather_next     = 32'd0;
            end else if (({1'b0, e_pos} + 3'd1) < width) begin
                byte_pos_next = e_pos + 2'd1;
                gather_next   = gathered;
            end else begin
                emit          = 1'b1;
                byte_pos_next = 2'd0;
                gather_next   = 32'd0;
                if (e_run) begin
                    pkt_left_next = 8'd0;
                end else begin
                    pkt_left_next = e_left - 8'd1;
                end
                if (pkt_left_next == 8'd0) begin
                    expect_hdr_next = 1'b1;
                end
                remaining_next = rem_after;
                if (rem_after == 32'd0) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    assign push             = byte_valid && emit;
    assign push_item.gather = gathered;
    assign push_item.wcode  = 2'(width - 3'd1);
    assign push_item.count  = count;
    assign push_item.last   = (rem_after == 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_hdr_reg <= 1'b1;
            is_run_reg     <= 1'b0;
            pkt_left_reg   <= 8'd0;
            byte_pos_reg   <= 2'd0;
            gather_reg     <= 32'd0;
            remaining_reg  <= PIXELS_RESET;
            done_reg       <= 1'b0;
        end else if (byte_valid) begin
            expect_hdr_reg <= expect_hdr_next;
            is_run_reg     <= is_run_next;
            pkt_left_reg   <= pkt_left_next;
            byte_pos_reg   <= byte_pos_next;
            gather_reg     <= gather_next;
            remaining_reg  <= remaining_next;
            done_reg       <= done_next;
        end
    end

endmodule

FILE: hw/rtl/tgarle_queue.sv
// Short queue of decoded pixels between front and back.
module tgarle_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tgarle_pkg::pix_item_t push_item,
    input  logic                  pop,
    output logic                  q_valid,
    output logic                  q_full,
    output tgarle_pkg::pix_item_t head_item
);
    import tgarle_pkg::*;

    pix_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign q_valid   = (cnt_reg != '0);
    assign q_full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/tgarle_back.sv
// Back end: byte reordering of 3-byte pixels and the output register.
module tgarle_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  tgarle_pkg::pix_item_t head_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           pixel_value,
    output logic [7:0]            repeat_count,
    output logic                  last_of_image
);
    import tgarle_pkg::*;

    logic        valid_reg;
    logic [31:0] pixel_reg, pixel_next;
    logic [7:0]  count_reg;
    logic        last_reg;

    // Swap red and blue; the top byte drops for 3-byte pixels
    always_comb begin
        if (head_item.wcode == WCODE_RGB) begin
            pixel_next = {8'd0, head_item.gather[7:0], head_item.gather[15:8],
                          head_item.gather[23:16]};
        end else begin
            pixel_next = head_item.gather;
        end
    end

    assign pop = q_valid && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pixel_reg <= pixel_next;
            count_reg <= head_item.count;
            last_reg  <= head_item.last;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_value   = pixel_reg;
    assign repeat_count  = count_reg;
    assign last_of_image = last_reg;

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder_core.sv
// Top level of the run-length TGA pixel decoder.
//
// Usage:
//   Input stream (s_*): one byte of the run-length coded packet stream per item
//   in s_tdata; s_tuser high restarts a new image with this byte as the first
//   packet header. Output stream (m_*): one pixel value with its repeat count
//   per item; m_tlast marks the item that completes the image. Bytes after the
//   last pixel are taken and dropped until the next restart.
//   Configuration: cfg_addr 0 is bytes per pixel (1..4), 1 is the image size in
//   pixels; a new size takes effect at the next restart. Write only while idle.
// Rate: one byte per clock while s_tready is high. A pixel byte that completes a
//   pixel gives a result through the front-to-back queue and then the output
//   register; the per-byte parse and the 32-bit clip of the remaining count lie
//   in the combinational front loop.
// Reset: synchronous, active low; width 3, image size 1, decoder waits for a
//   header, queue and output empty.
// Stall: while m_tready is low the queue takes up to two more pixels; then
//   s_tready drops until the receiver drains an item. Header and pixel bytes
//   that produce no result are taken as long as the queue is not full.
module tga_rle_pixel_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] first_of_image
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] pixel_value, [39:32] repeat_count
    output logic        m_tlast     // last_of_image
);
    import tgarle_pkg::*;

    logic      byte_valid;
    logic      push, pop, q_valid, q_full;
    pix_item_t push_item, head_item;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;

    // Accept a byte whenever the queue has room for the pixel it may finish
    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    tgarle_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .byte_valid     (byte_valid),
        .data_byte      (s_tdata),
        .first_of_image (s_tuser),
        .push           (push),
        .push_item      (push_item)
    );

    tgarle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head_item (head_item)
    );

    tgarle_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .last_of_image (m_tlast)
    );

    assign m_tdata = {repeat_count, pixel_value};

endmodule
